[rtl/mcr_pkg.sv]
// ----------------------------------------------------------------------------
// mcr_pkg
// Shared types and constants for the midpoint circle rasterizer.
// ----------------------------------------------------------------------------
package mcr_pkg;

    // default widths of coordinates and colour
    localparam int COORD_BITS_DEF = 16;
    localparam int COLOR_BITS_DEF = 32;

    // configuration register index
    localparam int CFG_IDX_BITS = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_U_MIN = 2'd0,
        CFG_V_MIN = 2'd1,
        CFG_U_MAX = 2'd2,
        CFG_V_MAX = 2'd3
    } t_cfg_idx;

    // request kinds carried in tuser
    typedef enum logic {
        REQ_LOAD    = 1'b0,
        REQ_ADVANCE = 1'b1
    } t_req;

    // screen rectangle after reset
    localparam int SCR_MIN_RST = 0;
    localparam int SCR_MAX_RST = 127;

    // number of mirrored points of one octant step
    localparam int OCT_POINTS = 8;
    localparam int OCT_IDX_BITS = 3;

endpackage

[rtl/midpoint_circle_rasterizer_unit.sv]
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer_unit
// Midpoint circle walk: a load request (tuser 0) latches centre, diameter and
// colour; each advance request (tuser 1) gives the eight mirrored points of
// the current octant step, each tested against the inclusive screen
// rectangle, with tlast on the last point of the step and a done flag on the
// last point of the circle. An advance on an idle block gives one invalid
// point marked done, and a one-pixel circle gives its centre alone. Results
// leave one per cycle through an output register while the result port is
// not stalled, and the next request is taken in the cycle the last point of
// the current step moves to the output register. Screen registers are
// written through the configuration channel; the user must do so only while
// no request is in flight, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer_unit #(
    parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF,
    parameter int COLOR_BITS = mcr_pkg::COLOR_BITS_DEF,
    localparam int S_DATA_W  = ((3 * COORD_BITS - 1 + COLOR_BITS + 7) / 8) * 8,
    localparam int M_DATA_W  = ((2 * (COORD_BITS + 1) + COLOR_BITS + 7) / 8) * 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // center_u, center_v, diameter, pen_color
    input  logic [S_DATA_W-1:0]               i_s_axis_tdata,
    // req_type
    input  logic [0:0]                        i_s_axis_tuser,
    // result channel
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // pixel_u, pixel_v, pixel_color
    output logic [M_DATA_W-1:0]               o_m_axis_tdata,
    // pixel_valid, circle_done
    output logic [1:0]                        o_m_axis_tuser,
    // step_last
    output logic                              o_m_axis_tlast,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mcr_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [COORD_BITS-1:0]             i_cfg_data
);
    import mcr_pkg::*;

    localparam int CB        = COORD_BITS;
    localparam int PB        = COORD_BITS + 1;
    localparam int DIAM_BITS = COORD_BITS - 1;
    localparam int ERR_BITS  = COORD_BITS + 4;

    localparam logic [ERR_BITS-1:0] ERR_THREE = ERR_BITS'(3);
    localparam logic [ERR_BITS-1:0] ERR_SIX   = ERR_BITS'(6);
    localparam logic [ERR_BITS-1:0] ERR_TEN   = ERR_BITS'(10);
    localparam logic [OCT_IDX_BITS-1:0] IDX_LAST = OCT_IDX_BITS'(OCT_POINTS - 1);

    // screen rectangle
    logic signed [CB-1:0] r_u_min, r_v_min, r_u_max, r_v_max;

    // walk state
    logic                 r_active;
    logic                 r_single;
    logic signed [CB-1:0] r_cu, r_cv;
    logic [COLOR_BITS-1:0] r_color;
    logic signed [CB-1:0] r_du, r_dv;
    logic signed [ERR_BITS-1:0] r_err;

    // step being issued
    logic                    r_job_valid;
    logic [OCT_IDX_BITS-1:0] r_job_idx;
    logic [OCT_IDX_BITS-1:0] r_job_last_idx;
    logic signed [CB-1:0]    r_job_cu, r_job_cv, r_job_du, r_job_dv;
    logic [COLOR_BITS-1:0]   r_job_color;
    logic                    r_job_en;
    logic                    r_job_done;

    // output register
    logic                    r_out_valid;
    logic signed [PB-1:0]    r_out_u, r_out_v;
    logic [COLOR_BITS-1:0]   r_out_color;
    logic                    r_out_pix_valid;
    logic                    r_out_last;
    logic                    r_out_done;

    // handshake terms
    logic out_free, issue, job_last, job_free, in_acc, adv_acc, load_acc;

    assign out_free = !r_out_valid || i_m_axis_tready;
    assign issue    = r_job_valid && out_free;
    assign job_last = (r_job_idx == r_job_last_idx);
    assign job_free = !r_job_valid || (issue && job_last);
    assign o_s_axis_tready = job_free;
    assign in_acc   = i_s_axis_tvalid && job_free;
    assign adv_acc  = in_acc && (i_s_axis_tuser[0] == REQ_ADVANCE);
    assign load_acc = in_acc && (i_s_axis_tuser[0] == REQ_LOAD);
    assign o_cfg_ready = 1'b1;

    // request fields
    logic signed [CB-1:0]   w_in_cu, w_in_cv;
    logic [DIAM_BITS-1:0]   w_diam, w_radius;
    logic [COLOR_BITS-1:0]  w_in_color;

    assign w_in_cu    = i_s_axis_tdata[0 +: CB];
    assign w_in_cv    = i_s_axis_tdata[CB +: CB];
    assign w_diam     = i_s_axis_tdata[2 * CB +: DIAM_BITS];
    assign w_in_color = i_s_axis_tdata[3 * CB - 1 +: COLOR_BITS];
    assign w_radius   = w_diam >> 1;

    // load values of the walk
    logic [ERR_BITS-1:0] n_err_load;
    logic [CB-1:0]       n_dv_load;

    assign n_dv_load  = {{(CB - DIAM_BITS){1'b0}}, w_radius};
    assign n_err_load = ERR_THREE - ({{(ERR_BITS - DIAM_BITS){1'b0}}, w_radius} << 1);

    // octant step update
    logic signed [CB-1:0]       n_du, n_dv_dec, n_dv;
    logic signed [ERR_BITS-1:0] n_du_e, n_dv_e, n_err;
    logic                       err_pos, walk_done;

    always_comb begin
        n_du     = r_du + CB'(1);
        n_dv_dec = r_dv - CB'(1);
        err_pos  = !r_err[ERR_BITS-1] && (|r_err);
        n_dv     = err_pos ? n_dv_dec : r_dv;
        n_du_e   = {{(ERR_BITS - CB){n_du[CB-1]}}, n_du};
        n_dv_e   = {{(ERR_BITS - CB){n_dv[CB-1]}}, n_dv};
        if (err_pos) begin
            n_err = r_err + ((n_du_e - n_dv_e) << 2) + ERR_TEN;
        end else begin
            n_err = r_err + (n_du_e << 2) + ERR_SIX;
        end
        walk_done = (n_dv < n_du);
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_min <= CB'(SCR_MIN_RST);
            r_v_min <= CB'(SCR_MIN_RST);
            r_u_max <= CB'(SCR_MAX_RST);
            r_v_max <= CB'(SCR_MAX_RST);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_U_MIN: r_u_min <= i_cfg_data;
                CFG_V_MIN: r_v_min <= i_cfg_data;
                CFG_U_MAX: r_u_max <= i_cfg_data;
                CFG_V_MAX: r_v_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // walk control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_single <= 1'b0;
        end else if (load_acc) begin
            r_active <= (w_diam != '0);
            r_single <= (w_diam != '0) && (w_radius == '0);
        end else if (adv_acc && r_active) begin
            if (r_single) begin
                r_active <= 1'b0;
                r_single <= 1'b0;
            end else if (walk_done) begin
                r_active <= 1'b0;
            end
        end
    end

    // walk payload
    always_ff @(posedge i_clk) begin
        if (load_acc) begin
            r_cu    <= w_in_cu;
            r_cv    <= w_in_cv;
            r_color <= w_in_color;
            r_du    <= '0;
            r_dv    <= n_dv_load;
            r_err   <= n_err_load;
        end else if (adv_acc && r_active && !r_single) begin
            r_du  <= n_du;
            r_dv  <= n_dv;
            r_err <= n_err;
        end
    end

    // step issue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_job_idx   <= '0;
        end else if (adv_acc) begin
            r_job_valid <= 1'b1;
            r_job_idx   <= '0;
        end else if (issue) begin
            if (job_last) begin
                r_job_valid <= 1'b0;
            end else begin
                r_job_idx <= r_job_idx + OCT_IDX_BITS'(1);
            end
        end
    end

    // step payload, a copy so that a later load cannot disturb it
    always_ff @(posedge i_clk) begin
        if (adv_acc) begin
            if (!r_active) begin
                r_job_cu       <= '0;
                r_job_cv       <= '0;
                r_job_du       <= '0;
                r_job_dv       <= '0;
                r_job_color    <= '0;
                r_job_en       <= 1'b0;
                r_job_done     <= 1'b1;
                r_job_last_idx <= '0;
            end else if (r_single) begin
                r_job_cu       <= r_cu;
                r_job_cv       <= r_cv;
                r_job_du       <= '0;
                r_job_dv       <= '0;
                r_job_color    <= r_color;
                r_job_en       <= 1'b1;
                r_job_done     <= 1'b1;
                r_job_last_idx <= '0;
            end else begin
                r_job_cu       <= r_cu;
                r_job_cv       <= r_cv;
                r_job_du       <= r_du;
                r_job_dv       <= r_dv;
                r_job_color    <= r_color;
                r_job_en       <= 1'b1;
                r_job_done     <= walk_done;
                r_job_last_idx <= IDX_LAST;
            end
        end
    end

    // mirrored point of the current index and its screen test
    logic signed [CB-1:0] w_off_a, w_off_b;
    logic signed [PB-1:0] w_a_e, w_b_e, w_cu_e, w_cv_e;
    logic signed [PB-1:0] n_pix_u, n_pix_v;
    logic signed [PB-1:0] w_umin_e, w_umax_e, w_vmin_e, w_vmax_e;
    logic                 n_inside;

    always_comb begin
        w_off_a  = r_job_idx[2] ? r_job_dv : r_job_du;
        w_off_b  = r_job_idx[2] ? r_job_du : r_job_dv;
        w_a_e    = {w_off_a[CB-1], w_off_a};
        w_b_e    = {w_off_b[CB-1], w_off_b};
        w_cu_e   = {r_job_cu[CB-1], r_job_cu};
        w_cv_e   = {r_job_cv[CB-1], r_job_cv};
        n_pix_u  = r_job_idx[0] ? (w_cu_e - w_a_e) : (w_cu_e + w_a_e);
        n_pix_v  = r_job_idx[1] ? (w_cv_e - w_b_e) : (w_cv_e + w_b_e);
        w_umin_e = {r_u_min[CB-1], r_u_min};
        w_umax_e = {r_u_max[CB-1], r_u_max};
        w_vmin_e = {r_v_min[CB-1], r_v_min};
        w_vmax_e = {r_v_max[CB-1], r_v_max};
        n_inside = (n_pix_u >= w_umin_e) && (n_pix_u <= w_umax_e) &&
                   (n_pix_v >= w_vmin_e) && (n_pix_v <= w_vmax_e);
    end

    // output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (issue) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_out_u         <= n_pix_u;
            r_out_v         <= n_pix_v;
            r_out_color     <= r_job_color;
            r_out_pix_valid <= r_job_en && n_inside;
            r_out_last      <= job_last;
            r_out_done      <= job_last && r_job_done;
        end
    end

    // result port packing
    always_comb begin
        o_m_axis_tdata = '0;
        o_m_axis_tdata[0 +: PB]                 = r_out_u;
        o_m_axis_tdata[PB +: PB]                = r_out_v;
        o_m_axis_tdata[2 * PB +: COLOR_BITS]    = r_out_color;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = {r_out_done, r_out_pix_valid};
    assign o_m_axis_tlast  = r_out_last;

    // checks
    a_done_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_done |-> r_out_last)
        else $error("circle done flagged on a point that is not the last of its step");

    a_adv_starts_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv_acc |=> r_job_valid && (r_job_idx == '0))
        else $error("advance request did not start a step at index zero");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid |-> (r_job_idx <= r_job_last_idx))
        else $error("step index ran past the last point");

    a_idx_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid && !issue && !adv_acc |=> $stable(r_job_idx) && r_job_valid)
        else $error("step moved on while the output register was full");

endmodule

[verif/midpoint_circle_rasterizer_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer_unit_tb
// Self-checking bench for the midpoint circle rasterizer. A directed table of
// loads and advances covers the idle block, zero and one-pixel circles,
// duplicate mirrored points, restarts and coordinate extremes. Random circle
// walks then run under several screen windows, including the full range and
// an empty one. Every pixel out of the block is compared field by field
// against a cycle-free model of the octant walk kept inside the bench.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer_unit_tb;
    import mcr_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int CB          = COORD_BITS_DEF;
    localparam int S_W         = ((3 * CB - 1 + COLOR_BITS_DEF + 7) / 8) * 8;
    localparam int M_W         = ((2 * (CB + 1) + COLOR_BITS_DEF + 7) / 8) * 8;
    localparam int PU_LSB      = 0;
    localparam int PV_LSB      = CB + 1;
    localparam int PC_LSB      = 2 * (CB + 1);
    localparam int LONG_HOLD   = 150;
    localparam int SETTLE_CYC  = 16;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        t_req               kind;
        logic signed [15:0] cu;
        logic signed [15:0] cv;
        logic [14:0]        diam;
        logic [31:0]        color;
    } t_circ_req;

    typedef struct {
        logic signed [16:0] u;
        logic signed [16:0] v;
        logic [31:0]        color;
        logic               valid;
        logic               last;
        logic               done;
    } t_pixel;

    typedef struct {
        t_circ_req rq;
        bit        typed;
        t_pixel    px;
    } t_dir_row;

    // dut ports
    logic             i_clk;
    logic             i_rst_n;
    logic             i_s_axis_tvalid;
    logic             o_s_axis_tready;
    logic [S_W-1:0]   i_s_axis_tdata;
    logic [0:0]       i_s_axis_tuser;
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready;
    logic [M_W-1:0]   o_m_axis_tdata;
    logic [1:0]       o_m_axis_tuser;
    logic             o_m_axis_tlast;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index;
    logic [CB-1:0]    i_cfg_data;

    // circle walk model state
    logic signed [15:0] scr_lo_u, scr_lo_v, scr_hi_u, scr_hi_v;
    bit                 walk_on;
    bit                 one_pixel;
    int                 ctr_u, ctr_v;
    logic [31:0]        pen;
    int                 off_u, off_v;
    int                 walk_err;

    t_pixel   step_pixels[$];
    t_pixel   pixel_expq[$];
    t_dir_row dir_rows[$];

    // bench control and statistics
    bit quiet;
    bit src_gaps;
    int holds_asked;
    int n_mismatch;
    int n_loads, n_advances, n_pixels_seen, n_valid_pixels, n_windows;
    int cycles;

    midpoint_circle_rasterizer_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // watchdog
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d pixels outstanding", $time, pixel_expq.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // error term lives in 20 bits and wraps
    function automatic int wrap20(input int x);
        logic signed [19:0] t;
        t = x[19:0];
        return t;
    endfunction

    function automatic bit in_screen(input int u, input int v);
        return u >= int'(scr_lo_u) && u <= int'(scr_hi_u) &&
               v >= int'(scr_lo_v) && v <= int'(scr_hi_v);
    endfunction

    function automatic t_pixel mk_pix(input int u, input int v, input logic [31:0] col,
                                      input bit valid, input bit last, input bit done);
        t_pixel px;
        px.u     = u[16:0];
        px.v     = v[16:0];
        px.color = col;
        px.valid = valid;
        px.last  = last;
        px.done  = done;
        return px;
    endfunction

    // one request through the octant walk, pixels land in step_pixels
    function automatic void predict_request(input t_circ_req rq);
        int pu[8];
        int pv[8];
        int du;
        int dv;
        int radius;
        bit fin;
        step_pixels.delete();
        if (rq.kind == REQ_LOAD) begin
            radius    = int'(rq.diam) >> 1;
            ctr_u     = rq.cu;
            ctr_v     = rq.cv;
            pen       = rq.color;
            walk_on   = (rq.diam != 0);
            one_pixel = walk_on && (radius == 0);
            off_u     = 0;
            off_v     = radius;
            walk_err  = wrap20(3 - 2 * radius);
        end else if (!walk_on) begin
            step_pixels.push_back(mk_pix(0, 0, 32'h0, 1'b0, 1'b1, 1'b1));
        end else if (one_pixel) begin
            step_pixels.push_back(mk_pix(ctr_u, ctr_v, pen, in_screen(ctr_u, ctr_v),
                                         1'b1, 1'b1));
            walk_on   = 1'b0;
            one_pixel = 1'b0;
        end else begin
            du = off_u;
            dv = off_v;
            pu[0] = ctr_u + du; pv[0] = ctr_v + dv;
            pu[1] = ctr_u - du; pv[1] = ctr_v + dv;
            pu[2] = ctr_u + du; pv[2] = ctr_v - dv;
            pu[3] = ctr_u - du; pv[3] = ctr_v - dv;
            pu[4] = ctr_u + dv; pv[4] = ctr_v + du;
            pu[5] = ctr_u - dv; pv[5] = ctr_v + du;
            pu[6] = ctr_u + dv; pv[6] = ctr_v - du;
            pu[7] = ctr_u - dv; pv[7] = ctr_v - du;
            // midpoint decision, du already stepped
            du = du + 1;
            if (walk_err > 0) begin
                dv = dv - 1;
                walk_err = wrap20(walk_err + 4 * (du - dv) + 10);
            end else begin
                walk_err = wrap20(walk_err + 4 * du + 6);
            end
            off_u = du;
            off_v = dv;
            fin = (dv < du);
            if (fin)
                walk_on = 1'b0;
            for (int k = 0; k < 8; k++)
                step_pixels.push_back(mk_pix(pu[k], pv[k], pen, in_screen(pu[k], pv[k]),
                                             k == 7, fin && k == 7));
        end
    endfunction

    function automatic t_circ_req mk_req(input t_req kind, input int cu, input int cv,
                                         input int d, input logic [31:0] col);
        t_circ_req rq;
        rq.kind  = kind;
        rq.cu    = 16'(cu);
        rq.cv    = 16'(cv);
        rq.diam  = 15'(d);
        rq.color = col;
        return rq;
    endfunction

    function automatic t_dir_row mk_row(input t_circ_req rq, input bit typed,
                                        input t_pixel px);
        t_dir_row r;
        r.rq    = rq;
        r.typed = typed;
        r.px    = px;
        return r;
    endfunction

    // a fresh circle: mostly small and near the windows, sometimes anything
    function automatic t_circ_req random_load();
        t_circ_req rq;
        int pick;
        rq.kind  = REQ_LOAD;
        rq.color = $urandom;
        if ($urandom_range(0, 1) == 0) begin
            rq.cu = 16'($urandom);
            rq.cv = 16'($urandom);
        end else begin
            rq.cu = 16'(int'($urandom_range(0, 400)) - 150);
            rq.cv = 16'(int'($urandom_range(0, 400)) - 150);
        end
        pick = $urandom_range(0, 19);
        if (pick < 12)
            rq.diam = 15'($urandom_range(0, 40));
        else if (pick < 17)
            rq.diam = 15'($urandom_range(41, 300));
        else
            rq.diam = 15'($urandom);
        return rq;
    endfunction

    function automatic t_circ_req random_any();
        t_circ_req rq;
        rq.kind  = ($urandom_range(0, 1) == 0) ? REQ_LOAD : REQ_ADVANCE;
        rq.cu    = 16'($urandom);
        rq.cv    = 16'($urandom);
        rq.diam  = 15'($urandom);
        rq.color = $urandom;
        return rq;
    endfunction

    // request side: offer one request, predict on acceptance
    task automatic send_item(input t_circ_req rq, input bit typed, input t_pixel typed_px);
        int gap;
        i_s_axis_tdata  <= {1'b0, rq.color, rq.diam, rq.cv, rq.cu};
        i_s_axis_tuser  <= rq.kind;
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_request(rq);
        if (typed)
            pixel_expq.push_back(typed_px);
        else
            foreach (step_pixels[k]) pixel_expq.push_back(step_pixels[k]);
        if (rq.kind == REQ_LOAD)
            n_loads++;
        else
            n_advances++;
        // random idle burst on the request side
        if (src_gaps && !quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 9);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // walks: load then advance until done or a cap, with some noise
    task automatic run_random(input int n_items);
        int sent;
        int steps;
        int cap;
        t_pixel none_px;
        sent = 0;
        none_px = mk_pix(0, 0, 32'h0, 1'b0, 1'b0, 1'b0);
        while (sent < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                send_item(random_any(), 1'b0, none_px);
                sent++;
            end else begin
                send_item(random_load(), 1'b0, none_px);
                sent++;
                steps = 0;
                cap = $urandom_range(4, 40);
                while (sent < n_items && walk_on && steps < cap) begin
                    send_item(mk_req(REQ_ADVANCE, 0, 0, 0, 32'h0), 1'b0, none_px);
                    sent++;
                    steps++;
                end
                // advance past the end of the circle now and then
                if (sent < n_items && !walk_on && $urandom_range(0, 3) == 0) begin
                    send_item(mk_req(REQ_ADVANCE, 0, 0, 0, 32'h0), 1'b0, none_px);
                    sent++;
                end
            end
        end
    endtask

    task automatic drain_pixels();
        while (pixel_expq.size() != 0) @(posedge i_clk);
    endtask

    // screen window write, registers back to back
    task automatic write_screen(input logic signed [15:0] lu, input logic signed [15:0] lv,
                                input logic signed [15:0] hu, input logic signed [15:0] hv);
        t_cfg_idx    idx;
        logic [15:0] val;
        for (int k = 0; k < 4; k++) begin
            idx = t_cfg_idx'(k);
            case (idx)
                CFG_U_MIN: val = lu;
                CFG_V_MIN: val = lv;
                CFG_U_MAX: val = hu;
                default:   val = hv;
            endcase
            i_cfg_index <= idx;
            i_cfg_data  <= val;
            i_cfg_valid <= 1'b1;
            do @(posedge i_clk); while (!o_cfg_ready);
            case (idx)
                CFG_U_MIN: scr_lo_u = val;
                CFG_V_MIN: scr_lo_v = val;
                CFG_U_MAX: scr_hi_u = val;
                default:   scr_hi_v = val;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    // let the block go idle, then move to a new window
    task automatic next_screen(input logic signed [15:0] lu, input logic signed [15:0] lv,
                               input logic signed [15:0] hu, input logic signed [15:0] hv);
        i_s_axis_tvalid <= 1'b0;
        drain_pixels();
        repeat (SETTLE_CYC) @(posedge i_clk);
        write_screen(lu, lv, hu, hv);
        n_windows++;
    endtask

    task automatic build_directed();
        t_pixel idle_px;
        t_pixel none_px;
        t_circ_req adv;
        idle_px = mk_pix(0, 0, 32'h0, 1'b0, 1'b1, 1'b1);
        none_px = mk_pix(0, 0, 32'h0, 1'b0, 1'b0, 1'b0);
        adv = mk_req(REQ_ADVANCE, 0, 0, 0, 32'h0);
        // advance on an idle block right after reset
        dir_rows.push_back(mk_row(adv, 1'b1, idle_px));
        // zero diameter leaves the block idle
        dir_rows.push_back(mk_row(mk_req(REQ_LOAD, 5, 5, 0, 32'hDEAD_BEEF), 1'b0, none_px));
        dir_rows.push_back(mk_row(adv, 1'b1, idle_px));
        // one-pixel circle, then idle again
        dir_rows.push_back(mk_row(mk_req(REQ_LOAD, 10, 20, 1, 32'hFFFF_FFFF), 1'b0, none_px));
        dir_rows.push_back(mk_row(adv, 1'b1, mk_pix(10, 20, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1)));
        dir_rows.push_back(mk_row(adv, 1'b1, idle_px));
        // radius 5 walk to completion
        dir_rows.push_back(mk_row(mk_req(REQ_LOAD, 64, 64, 10, 32'hA5A5_A5A5), 1'b0, none_px));
        repeat (4) dir_rows.push_back(mk_row(adv, 1'b0, none_px));
        dir_rows.push_back(mk_row(adv, 1'b1, idle_px));
        // coordinate and diameter extremes
        dir_rows.push_back(mk_row(mk_req(REQ_LOAD, -32768, 32767, 32767, 32'h0), 1'b0, none_px));
        repeat (2) dir_rows.push_back(mk_row(adv, 1'b0, none_px));
        dir_rows.push_back(mk_row(mk_req(REQ_LOAD, 32767, -32768, 32766, 32'h8000_0000),
                                  1'b0, none_px));
        dir_rows.push_back(mk_row(adv, 1'b0, none_px));
        // restart mid-walk, radius 1 gives duplicate points
        dir_rows.push_back(mk_row(mk_req(REQ_LOAD, 0, 0, 2, 32'h0000_FFFF), 1'b0, none_px));
        dir_rows.push_back(mk_row(adv, 1'b0, none_px));
        dir_rows.push_back(mk_row(adv, 1'b1, idle_px));
        // circle on the screen corner
        dir_rows.push_back(mk_row(mk_req(REQ_LOAD, 127, 127, 3, 32'h1234_5678), 1'b0, none_px));
        dir_rows.push_back(mk_row(adv, 1'b0, none_px));
        // one-pixel circle off screen
        dir_rows.push_back(mk_row(mk_req(REQ_LOAD, 128, -1, 1, 32'h0000_0001), 1'b0, none_px));
        dir_rows.push_back(mk_row(adv, 1'b1, mk_pix(128, -1, 32'h1, 1'b0, 1'b1, 1'b1)));
    endtask

    // result side: random stalls plus one long hold-off on request
    initial begin : pixel_sink
        int wait_left;
        int holds_served;
        wait_left = 0;
        holds_served = 0;
        i_m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (wait_left > 0) begin
                wait_left = wait_left - 1;
                i_m_axis_tready <= 1'b0;
            end else if (holds_served != holds_asked) begin
                holds_served = holds_served + 1;
                wait_left = LONG_HOLD - 1;
                i_m_axis_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 11) == 0) begin
                wait_left = $urandom_range(0, 8);
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // compare each accepted pixel with the oldest prediction
    always @(posedge i_clk) begin : pixel_check
        t_pixel got;
        t_pixel want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.u     = o_m_axis_tdata[PU_LSB +: CB + 1];
            got.v     = o_m_axis_tdata[PV_LSB +: CB + 1];
            got.color = o_m_axis_tdata[PC_LSB +: COLOR_BITS_DEF];
            got.valid = o_m_axis_tuser[0];
            got.done  = o_m_axis_tuser[1];
            got.last  = o_m_axis_tlast;
            n_pixels_seen++;
            if (pixel_expq.size() == 0) begin
                $display("%0t: pixel with none expected, got u=%0d v=%0d",
                         $time, got.u, got.v);
                n_mismatch++;
            end else begin
                want = pixel_expq.pop_front();
                if (want.valid)
                    n_valid_pixels++;
                if (got.u !== want.u) begin
                    $display("%0t: pixel_u expected %0d got %0d", $time, want.u, got.u);
                    n_mismatch++;
                end
                if (got.v !== want.v) begin
                    $display("%0t: pixel_v expected %0d got %0d", $time, want.v, got.v);
                    n_mismatch++;
                end
                if (got.color !== want.color) begin
                    $display("%0t: pixel_color expected %h got %h",
                             $time, want.color, got.color);
                    n_mismatch++;
                end
                if (got.valid !== want.valid) begin
                    $display("%0t: pixel_valid expected %b got %b",
                             $time, want.valid, got.valid);
                    n_mismatch++;
                end
                if (got.last !== want.last) begin
                    $display("%0t: step_last expected %b got %b", $time, want.last, got.last);
                    n_mismatch++;
                end
                if (got.done !== want.done) begin
                    $display("%0t: circle_done expected %b got %b", $time, want.done, got.done);
                    n_mismatch++;
                end
            end
        end
    end

    // main sequence
    initial begin : stimulus
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= REQ_LOAD;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= CFG_U_MIN;
        i_cfg_data      <= '0;
        scr_lo_u  = 16'(SCR_MIN_RST);
        scr_lo_v  = 16'(SCR_MIN_RST);
        scr_hi_u  = 16'(SCR_MAX_RST);
        scr_hi_v  = 16'(SCR_MAX_RST);
        walk_on   = 1'b0;
        one_pixel = 1'b0;
        ctr_u     = 0;
        ctr_v     = 0;
        pen       = 32'h0;
        off_u     = 0;
        off_v     = 0;
        walk_err  = 0;
        quiet       = 1'b0;
        src_gaps    = 1'b1;
        holds_asked = 0;
        n_mismatch  = 0;
        n_loads = 0; n_advances = 0; n_pixels_seen = 0; n_valid_pixels = 0;
        n_windows = 1;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table under the reset window
        build_directed();
        foreach (dir_rows[k])
            send_item(dir_rows[k].rq, dir_rows[k].typed, dir_rows[k].px);

        // full coordinate range
        next_screen(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
        run_random(120);

        // empty window, min above max
        next_screen(16'sd100, 16'sd100, -16'sd100, -16'sd100);
        run_random(60);

        // tight window, result side blocked while requests keep coming
        next_screen(-16'sd20, -16'sd10, 16'sd20, 16'sd10);
        holds_asked = holds_asked + 1;
        src_gaps = 1'b0;
        run_random(40);
        src_gaps = 1'b1;
        run_random(80);

        // random window, request side pauses until all pixels are back
        next_screen(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        run_random(50);
        i_s_axis_tvalid <= 1'b0;
        drain_pixels();
        @(posedge i_clk);
        run_random(50);

        // back to the reset window, no idling at all
        next_screen(16'(SCR_MIN_RST), 16'(SCR_MIN_RST), 16'(SCR_MAX_RST), 16'(SCR_MAX_RST));
        quiet = 1'b1;
        run_random(80);
        i_s_axis_tvalid <= 1'b0;

        drain_pixels();
        repeat (SETTLE_CYC) @(posedge i_clk);

        $display("covered %0d loads and %0d advances over %0d screen windows",
                 n_loads, n_advances, n_windows);
        $display("checked %0d pixels, %0d on screen, %0d mismatches",
                 n_pixels_seen, n_valid_pixels, n_mismatch);
        if (n_mismatch == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
